// ===== hw/rtl/cnms_pkg.sv =====
package cnms_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAG_W = 12;
	localparam int GRAD_W = 11;
	localparam int IW_W = 11;
	localparam int IH_W = 12;

	localparam logic [IW_W-1:0] WIDTH_RST = 11'd640;
	localparam logic [IH_W-1:0] HEIGHT_RST = 12'd480;
	localparam logic [7:0] THRESH_RST = 8'd25;

	// tan 22 and tan 23 degrees scaled by 10^12
	localparam logic [39:0] TAN_SCALE = 40'd1000000000000;
	localparam logic [39:0] TAN22_FX = 40'd404026225835;
	localparam logic [39:0] TAN23_FX = 40'd424474816210;

	typedef enum logic [1:0] {
		SEC_HORZ = 2'd0,
		SEC_DIAG_UP = 2'd1,
		SEC_VERT = 2'd2,
		SEC_DIAG_DN = 2'd3
	} sector_t;

	typedef enum logic [1:0] {
		REG_WIDTH = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BINARIZE = 2'd2,
		REG_THRESH = 2'd3
	} reg_idx_t;

	// result of the front stage handed to the window stage
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [3:0] cmp;
		logic gx_neg;
		logic gy_pos;
		logic ay_zero;
	} front_t;

endpackage

// ===== hw/rtl/cnms_sector.sv =====
module cnms_sector (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [cnms_pkg::GRAD_W-1:0] gx,
	input  logic signed [cnms_pkg::GRAD_W-1:0] gy,
	output cnms_pkg::front_t              res_s1,
	output cnms_pkg::sector_t             sec_s1
);
	logic [cnms_pkg::GRAD_W-1:0] ax, ay;
	logic [50:0] ay_s, ay_22, ay_23, ax_s, ax_22, ax_23;
	cnms_pkg::front_t nxt;

	assign ax = gx[cnms_pkg::GRAD_W-1] ? (~gx + 1'b1) : gx;
	assign ay = gy[cnms_pkg::GRAD_W-1] ? (~gy + 1'b1) : gy;
	assign ay_s  = 51'(ay) * 51'(cnms_pkg::TAN_SCALE);
	assign ay_22 = 51'(ay) * 51'(cnms_pkg::TAN22_FX);
	assign ay_23 = 51'(ay) * 51'(cnms_pkg::TAN23_FX);
	assign ax_s  = 51'(ax) * 51'(cnms_pkg::TAN_SCALE);
	assign ax_22 = 51'(ax) * 51'(cnms_pkg::TAN22_FX);
	assign ax_23 = 51'(ax) * 51'(cnms_pkg::TAN23_FX);

	always_comb begin
		nxt.mag = 12'(ax) + 12'(ay);
		nxt.cmp[0] = ay_s < ax_23;
		nxt.cmp[1] = ay_22 < ax_s;
		nxt.cmp[2] = ay_s < ax_22;
		nxt.cmp[3] = ay_23 < ax_s;
		nxt.gx_neg = gx[cnms_pkg::GRAD_W-1];
		nxt.gy_pos = !gy[cnms_pkg::GRAD_W-1] && (gy != '0);
		nxt.ay_zero = (gy == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= nxt;
		end
	end

	always_comb begin
		if (res_s1.ay_zero) begin
			sec_s1 = cnms_pkg::SEC_HORZ;
		end else if (!res_s1.gx_neg) begin
			if (res_s1.cmp[0]) sec_s1 = cnms_pkg::SEC_HORZ;
			else if (res_s1.cmp[1])
				sec_s1 = res_s1.gy_pos ? cnms_pkg::SEC_DIAG_UP : cnms_pkg::SEC_DIAG_DN;
			else sec_s1 = cnms_pkg::SEC_VERT;
		end else begin
			if (res_s1.cmp[2]) sec_s1 = cnms_pkg::SEC_HORZ;
			else if (res_s1.cmp[3])
				sec_s1 = res_s1.gy_pos ? cnms_pkg::SEC_DIAG_DN : cnms_pkg::SEC_DIAG_UP;
			else sec_s1 = cnms_pkg::SEC_VERT;
		end
	end
endmodule

// ===== hw/rtl/canny_nonmax_suppression.sv =====
// Canny non-maximum suppression on a raster stream of gradient pairs. One transaction
// per clock is sustained: each input pixel passes a tangent-compare stage and a line
// memory read stage, then the window stage loads a one-entry output register plus skid
// register, so a result is offered by the output register after the transaction that
// completes pixel (r-1,c-1) has passed the window stage; input is only held when both
// registers are full. Line memories are cleared after reset by a sweep of all MAX_WIDTH
// entries during which in_ready is low; configuration writes are taken throughout.
module canny_nonmax_suppression #(
	parameter int MAX_WIDTH = cnms_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [10:0] grad_x,
	input  logic signed [10:0] grad_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  edge_pixel,
	output logic        frame_end
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int MW = cnms_pkg::MAG_W;

	// configuration registers
	logic [10:0] width_q;
	logic [11:0] height_q;
	logic        bin_q;
	logic [7:0]  thresh_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cnms_pkg::WIDTH_RST;
			height_q <= cnms_pkg::HEIGHT_RST;
			bin_q <= 1'b1;
			thresh_q <= cnms_pkg::THRESH_RST;
		end else if (cfg_valid) begin
			unique case (cnms_pkg::reg_idx_t'(cfg_index))
				cnms_pkg::REG_WIDTH:    width_q <= cfg_data[10:0];
				cnms_pkg::REG_HEIGHT:   height_q <= cfg_data;
				cnms_pkg::REG_BINARIZE: bin_q <= cfg_data[0];
				cnms_pkg::REG_THRESH:   thresh_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// effective sizes, last index
	logic [CW-1:0] wlast;
	logic [11:0]   hlast;
	always_comb begin
		if (width_q < 11'd3) wlast = CW'(2);
		else if (32'(width_q) > MAX_WIDTH) wlast = CW'(MAX_WIDTH - 1);
		else wlast = CW'(width_q - 11'd1);
		hlast = (height_q < 12'd3) ? 12'd2 : height_q - 12'd1;
	end

	// clearing sweep after reset
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (32'(clr_addr_q) == MAX_WIDTH - 1) clr_q <= 1'b0;
		end
	end

	// output register with skid
	logic       skid_v_q, out_v_q;
	logic [8:0] skid_q, out_q;
	logic       adv;
	logic       s1_v, s2_v;

	// stall pipeline when a result would have no room
	assign adv = !(out_v_q && !out_ready && skid_v_q);
	assign in_ready = adv && !clr_q;
	wire acc = in_valid && in_ready;

	// stage 1: sector compare and counters
	cnms_pkg::front_t  f_s1;
	cnms_pkg::sector_t sec_s1;
	cnms_sector u_sec (
		.clk(clk), .en(acc), .gx(grad_x), .gy(grad_y),
		.res_s1(f_s1), .sec_s1(sec_s1)
	);

	logic [AW-1:0] col_q, col_s1;
	logic [11:0]   row_q;
	logic          emit_s1, fend_s1;
	wire  [CW-1:0] colx = CW'(col_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			s1_v <= 1'b0;
		end else if (adv) begin
			s1_v <= acc;
			if (acc) begin
				if (colx >= wlast) begin
					col_q <= '0;
					row_q <= (row_q >= hlast) ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1 <= col_q;
			emit_s1 <= (row_q >= 12'd2) && (colx >= CW'(2));
			fend_s1 <= (row_q >= hlast) && (colx >= wlast);
		end
	end

	// line memories: read at stage 0, written at stage 1
	logic [2*MW-1:0] mag_mem [MAX_WIDTH];
	logic [1:0]      sec_mem [MAX_WIDTH];
	logic [2*MW-1:0] mag_rd;
	logic [1:0]      sec_rd;
	logic [2*MW-1:0] fwd_mag_q;
	logic [1:0]      fwd_sec_q;
	logic            fwd_q;

	wire wr_en = clr_q || (s1_v && adv);
	wire [AW-1:0] wr_addr = clr_q ? clr_addr_q : col_s1;
	wire [MW-1:0] mid_s1 = fwd_q ? fwd_mag_q[MW-1:0] : mag_rd[MW-1:0];
	wire [MW-1:0] top_s1 = fwd_q ? fwd_mag_q[2*MW-1:MW] : mag_rd[2*MW-1:MW];
	wire [1:0]    osec_s1 = fwd_q ? fwd_sec_q : sec_rd;
	wire [2*MW-1:0] wr_mag = clr_q ? '0 : {mid_s1, f_s1.mag};
	wire [1:0]    wr_sec = clr_q ? 2'd0 : 2'(sec_s1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mag_mem[wr_addr] <= wr_mag;
			sec_mem[wr_addr] <= wr_sec;
		end
		if (acc) begin
			mag_rd <= mag_mem[col_q];
			sec_rd <= sec_mem[col_q];
		end
	end
	// a read of the entry being written this cycle takes the written data
	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_q <= wr_en && (wr_addr == col_q);
			fwd_mag_q <= wr_mag;
			fwd_sec_q <= wr_sec;
		end
	end

	// 3x3 window and sector delay
	logic [MW-1:0] win_q [3][3];
	logic [1:0]    csec_q;
	logic [1:0]    csec_s2;
	logic          fend_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
			csec_q <= '0;
			csec_s2 <= '0;
			fend_s2 <= 1'b0;
			s2_v <= 1'b0;
		end else if (adv) begin
			s2_v <= s1_v && emit_s1;
			if (s1_v) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= top_s1;
				win_q[1][2] <= mid_s1;
				win_q[2][2] <= f_s1.mag;
				csec_q <= osec_s1;
				csec_s2 <= csec_q;
				fend_s2 <= fend_s1;
			end
		end
	end

	// suppression on the shifted window
	logic [MW-1:0] n1, n2, cen;
	logic [7:0]    v;
	always_comb begin
		cen = win_q[1][1];
		unique case (cnms_pkg::sector_t'(csec_s2))
			cnms_pkg::SEC_HORZ:    begin n1 = win_q[1][0]; n2 = win_q[1][2]; end
			cnms_pkg::SEC_DIAG_UP: begin n1 = win_q[2][0]; n2 = win_q[0][2]; end
			cnms_pkg::SEC_VERT:    begin n1 = win_q[2][1]; n2 = win_q[0][1]; end
			default:               begin n1 = win_q[0][0]; n2 = win_q[2][2]; end
		endcase
		if (n1 > cen || n2 > cen) v = 8'd0;
		else v = (cen > 12'd255) ? 8'd255 : cen[7:0];
		if (bin_q) v = (v <= thresh_q) ? 8'd0 : 8'd255;
	end

	wire res_v = s2_v && adv;
	wire [8:0] res_d = {fend_s2, v};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_ready) begin
				out_v_q <= skid_v_q || res_v;
				skid_v_q <= skid_v_q && res_v;
			end else if (res_v) begin
				skid_v_q <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			out_q <= skid_v_q ? skid_q : res_d;
			if (res_v) skid_q <= res_d;
		end else if (res_v) begin
			skid_q <= res_d;
		end
	end
	assign out_valid = out_v_q;
	assign edge_pixel = out_q[7:0];
	assign frame_end = out_q[8];

	a_no_in_clr: assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !in_ready)
		else $error("input taken during clear");
	a_skid: assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid full with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && skid_v_q && !out_ready) |-> !in_ready)
		else $error("input accepted with no room");
endmodule

// ===== test/canny_nms_checker.sv =====
module canny_nms_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [11:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic signed [10:0] grad_x,
	input  logic signed [10:0] grad_y,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [7:0]        edge_pixel,
	input  logic              frame_end,
	output int                fail_count,
	output int                pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX = 1024;

	typedef struct packed {
		logic [7:0] pix;
		logic       last;
	} edge_out_t;

	logic [10:0] width_reg;
	logic [11:0] height_reg;
	logic        bin_en;
	logic [7:0]  thresh;

	logic [11:0] mag_top [LINE_MAX];
	logic [11:0] mag_mid [LINE_MAX];
	cnms_pkg::sector_t sec_line [LINE_MAX];
	logic [11:0] win [3][3];
	int          col_cnt, row_cnt;
	cnms_pkg::sector_t sec_dly;
	edge_out_t   edge_q [$];

	function automatic cnms_pkg::sector_t sector_of(logic signed [10:0] gx,
			logic signed [10:0] gy);
		logic [79:0] ax, ay;
		ax = (gx < 0) ? -gx : gx;
		ay = (gy < 0) ? -gy : gy;
		if (ay == 0)
			return cnms_pkg::SEC_HORZ;
		if (gx >= 0) begin
			if (ay * 80'(cnms_pkg::TAN_SCALE) < ax * 80'(cnms_pkg::TAN23_FX))
				return cnms_pkg::SEC_HORZ;
			if (ay * 80'(cnms_pkg::TAN22_FX) < ax * 80'(cnms_pkg::TAN_SCALE))
				return (gy > 0) ? cnms_pkg::SEC_DIAG_UP : cnms_pkg::SEC_DIAG_DN;
			return cnms_pkg::SEC_VERT;
		end
		if (ay * 80'(cnms_pkg::TAN_SCALE) < ax * 80'(cnms_pkg::TAN22_FX))
			return cnms_pkg::SEC_HORZ;
		if (ay * 80'(cnms_pkg::TAN23_FX) < ax * 80'(cnms_pkg::TAN_SCALE))
			return (gy > 0) ? cnms_pkg::SEC_DIAG_DN : cnms_pkg::SEC_DIAG_UP;
		return cnms_pkg::SEC_VERT;
	endfunction

	task automatic predict_pixel(logic signed [10:0] gx, logic signed [10:0] gy);
		int w, h, c, r, v;
		logic [11:0] mag, top, mid, ctr, n1, n2;
		cnms_pkg::sector_t sec, csec;
		w = (width_reg < 3) ? 3 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
		h = (height_reg < 3) ? 3 : height_reg;
		c = (col_cnt < LINE_MAX) ? col_cnt : LINE_MAX - 1;
		r = row_cnt;
		mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
		sec = sector_of(gx, gy);
		top = mag_top[c];
		mid = mag_mid[c];
		csec = sec_dly;
		mag_top[c] = mid;
		mag_mid[c] = mag;
		sec_dly = sec_line[c];
		sec_line[c] = sec;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = mag;
		if (r >= 2 && c >= 2) begin
			ctr = win[1][1];
			case (csec)
				cnms_pkg::SEC_HORZ: begin n1 = win[1][0]; n2 = win[1][2]; end
				cnms_pkg::SEC_DIAG_UP: begin n1 = win[2][0]; n2 = win[0][2]; end
				cnms_pkg::SEC_VERT: begin n1 = win[2][1]; n2 = win[0][1]; end
				default: begin n1 = win[0][0]; n2 = win[2][2]; end
			endcase
			if (n1 > ctr || n2 > ctr)
				v = 0;
			else
				v = (ctr > 255) ? 255 : ctr;
			if (bin_en)
				v = (v <= thresh) ? 0 : 255;
			edge_q.push_back('{pix: 8'(v), last: (r >= h - 1 && c >= w - 1)});
		end
		if (c >= w - 1) begin
			col_cnt = 0;
			row_cnt = (r >= h - 1) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_out_t exp_e;
		if (!arst_n) begin
			width_reg <= cnms_pkg::WIDTH_RST;
			height_reg <= cnms_pkg::HEIGHT_RST;
			bin_en <= 1'b1;
			thresh <= cnms_pkg::THRESH_RST;
			for (int i = 0; i < LINE_MAX; i++) begin
				mag_top[i] = '0;
				mag_mid[i] = '0;
				sec_line[i] = cnms_pkg::SEC_HORZ;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			col_cnt = 0;
			row_cnt = 0;
			sec_dly = cnms_pkg::SEC_HORZ;
			edge_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cnms_pkg::reg_idx_t'(cfg_index))
					cnms_pkg::REG_WIDTH: width_reg <= cfg_data[10:0];
					cnms_pkg::REG_HEIGHT: height_reg <= cfg_data;
					cnms_pkg::REG_BINARIZE: bin_en <= cfg_data[0];
					cnms_pkg::REG_THRESH: thresh <= cfg_data[7:0];
				endcase
			end
			if (out_valid && out_ready) begin
				if (edge_q.size() == 0) begin
					$display("%0t: unexpected transaction edge_pixel=%0d frame_end=%0d",
						$time, edge_pixel, frame_end);
					fail_count <= fail_count + 1;
				end else begin
					exp_e = edge_q.pop_front();
					if (exp_e.pix !== edge_pixel || exp_e.last !== frame_end) begin
						$display("%0t: mismatch expected pixel=%0d end=%0d actual pixel=%0d end=%0d",
							$time, exp_e.pix, exp_e.last, edge_pixel, frame_end);
						fail_count <= fail_count + 1;
					end
				end
			end
			// results of this edge's input cannot leave before the next edge
			if (in_valid && in_ready)
				predict_pixel(grad_x, grad_y);
			pending_count <= edge_q.size();
		end
	end
endmodule

// ===== test/tb_canny_nonmax_suppression.sv =====
module tb_canny_nonmax_suppression;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [11:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [10:0] grad_x, grad_y;
	logic out_valid, out_ready;
	logic [7:0] edge_pixel;
	logic frame_end;
	int fail_count, pending_count;

	// idle percentages per side, changed between phases
	int send_idle_pct, recv_idle_pct;
	// long receiver hold-off, requested by the stimulus and counted by the receiver
	int hold_req, hold_ack, hold_cycles;

	canny_nonmax_suppression dut (.*);

	canny_nms_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			hold_ack <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= 200;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(cnms_pkg::reg_idx_t idx, logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// one transaction on the gradient channel, with random idle before it
	task automatic send_grad(int gx, int gy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		grad_x <= 11'(gx);
		grad_y <= 11'(gy);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		// give the last transaction time to reach the checker's count
		repeat (4) @(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(int w, int h, logic b, logic [7:0] t);
		write_reg(cnms_pkg::REG_WIDTH, 12'(w));
		write_reg(cnms_pkg::REG_HEIGHT, 12'(h));
		write_reg(cnms_pkg::REG_BINARIZE, {11'd0, b});
		write_reg(cnms_pkg::REG_THRESH, {4'd0, t});
		cfg_valid <= 1'b0;
	endtask

	// random gradient: mix of small, full-range and axis-aligned values
	task automatic send_random_frame(int n);
		int gx, gy;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					gx = int'($urandom_range(2047)) - 1024;
					gy = int'($urandom_range(2047)) - 1024;
				end
				1: begin
					gx = int'($urandom_range(60)) - 30;
					gy = int'($urandom_range(60)) - 30;
				end
				2: begin
					gx = ($urandom_range(1) != 0) ? 0 : int'($urandom_range(2047)) - 1024;
					gy = int'($urandom_range(2047)) - 1024;
				end
				default: begin
					gx = int'($urandom_range(400)) - 200;
					gy = ($urandom_range(1) != 0) ? 0 : int'($urandom_range(400)) - 200;
				end
			endcase
			send_grad(gx, gy);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = cnms_pkg::REG_WIDTH; cfg_data = 0;
		in_valid = 0; grad_x = 0; grad_y = 0;
		send_idle_pct = 27; recv_idle_pct = 46; hold_req = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: a tiny 5x4 frame on extremes and sector boundaries
		set_size(5, 4, 1'b0, 8'd0);
		send_grad(-1024, -1024); send_grad(1023, 1023); send_grad(0, 0);
		send_grad(0, 5); send_grad(0, -5); send_grad(100, 40); send_grad(100, 41);
		send_grad(-100, 40); send_grad(-100, 41); send_grad(40, 100); send_grad(-40, 100);
		send_grad(100, -40); send_grad(-100, -41); send_grad(1023, 0); send_grad(-1024, 0);
		send_grad(-1, 1); send_grad(1, -1); send_grad(200, 200); send_grad(7, 0);
		send_grad(0, 1023);
		drain();

		// out-of-range sizes saturate; binarize at threshold extremes
		set_size(0, 0, 1'b1, 8'd255);
		send_random_frame(18);
		drain();
		set_size(3, 3, 1'b1, 8'd0);
		send_random_frame(27);
		drain();

		// phase 1: sender 27 percent, receiver 46 percent
		set_size(17, 9, 1'b0, 8'd25);
		send_random_frame(17 * 9 + 47);
		// sender waits for every result before going on
		drain();
		// oversized width, left mid-line so the next size change wraps the counters
		set_size(2047, 4095, 1'b1, 8'd100);
		send_random_frame(300);
		drain();

		// phase 2: roles swapped, with a long receiver hold-off
		send_idle_pct = 46; recv_idle_pct = 27;
		set_size(11, 4095, 1'b0, 8'd0);
		hold_req <= hold_req + 1;
		send_random_frame(150);
		send_random_frame(150);
		drain();

		// phase 3: no idling
		send_idle_pct = 0; recv_idle_pct = 0;
		set_size(6, 20, 1'b1, 8'd60);
		send_random_frame(6 * 20 + 70);
		drain();
		set_size(40, 6, 1'b0, 8'd0);
		send_random_frame(250);
		drain();

		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
